// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error("assertion failed");

// check a property including during reset
`define ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error("assertion failed");

`endif

// ===== rtl/salru_pkg.sv =====
// ----------------------------------------------------------------------------
// salru_pkg
// shared types and codes for the set associative cache lookup
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

  localparam logic [1:0] ACT_INSTR = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_OTHER = 2'd3;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_ACTIVE_WAYS = 2'd2;

  // request handed from the front to the back
  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] tag;
    logic [15:0] set;
  } salru_req_t;

endpackage

`default_nettype wire

// ===== rtl/salru_ram.sv =====
// ----------------------------------------------------------------------------
// salru_ram
// generic simple dual port ram (one write port, one read port), registered read
// ----------------------------------------------------------------------------
`default_nettype none

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/salru_front.sv =====
// ----------------------------------------------------------------------------
// salru_front
// splits the address into set and tag and queues the request
// ----------------------------------------------------------------------------
`default_nettype none

module salru_front
  import salru_pkg::*;
#(
  parameter int SETS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [3:0]  offset_bits,
  input  wire logic [3:0]  index_bits,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_address,
  output logic             q_valid,
  input  wire logic        q_ready,
  output salru_req_t       q_req
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

  salru_req_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  salru_req_t req_in;
  logic [63:0] shifted;
  logic [63:0] imask;
  logic [4:0]  tag_sh;
  logic        push;
  logic        pop;

  always_comb begin
    shifted = in_address >> offset_bits;
    imask   = (64'd1 << index_bits) - 64'd1;
    tag_sh  = {1'b0, offset_bits} + {1'b0, index_bits};
    req_in.action = in_action;
    req_in.tag    = in_address >> tag_sh;
    req_in.set    = '0;
    req_in.set[SW-1:0] = (SETS > 1) ? shifted[SW-1:0] & imask[SW-1:0] : '0;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/salru_back.sv =====
// ----------------------------------------------------------------------------
// salru_back
// clears every set after reset; reads the set, picks the way, writes back tags and ages, counts
// ----------------------------------------------------------------------------
`default_nettype none

module salru_back
  import salru_pkg::*;
#(
  parameter int SETS     = 256,
  parameter int WAYS     = 4,
  parameter int AGE_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [2:0]  active_ways,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire salru_req_t  q_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [1:0]       out_way,
  output logic [31:0]      out_ref_count,
  output logic [31:0]      out_miss_count,
  output logic             busy
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW = 64 + 1 + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  logic [1:0]    state;
  salru_req_t    cur;
  logic [SW-1:0] clr_set;
  logic [31:0]   ref_cnt  [3];
  logic [31:0]   miss_cnt [3];

  logic [EW-1:0]  rdata [WAYS];
  logic [EW-1:0]  wdata [WAYS];
  logic [SW-1:0]  raddr;
  logic [SW-1:0]  waddr;
  logic           we;
  logic [WW:0]    nways;
  logic           hit;
  logic [WW-1:0]  sel_way;

  always_comb begin
    nways = (active_ways == 3'd0) ? (WW+1)'(1) : (WW+1)'(active_ways);
    if (32'(active_ways) > WAYS) nways = (WW+1)'(WAYS);
  end

  genvar g;
  generate
    for (g = 0; g < WAYS; g++) begin : g_way
      salru_ram #(.WIDTH(EW), .DEPTH(1 << SW)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata[g]),
        .raddr(raddr),
        .rdata(rdata[g])
      );
    end
  endgenerate

  // way choice: first hit, else first invalid, else oldest (lowest on tie)
  always_comb begin
    logic found;
    logic free;
    logic [AGE_BITS-1:0] best;
    hit = 1'b0;
    sel_way = '0;
    found = 1'b0;
    free = 1'b0;
    best = rdata[0][AGE_BITS-1:0];
    for (int i = 0; i < WAYS; i++) begin
      if ((WW+1)'(i) < nways && !found && rdata[i][AGE_BITS] &&
          rdata[i][EW-1:AGE_BITS+1] == cur.tag) begin
        found = 1'b1;
        sel_way = WW'(i);
      end
    end
    hit = found;
    if (!found) begin
      for (int i = 0; i < WAYS; i++) begin
        if ((WW+1)'(i) < nways && !free && !rdata[i][AGE_BITS]) begin
          free = 1'b1;
          sel_way = WW'(i);
        end
      end
      if (!free) begin
        sel_way = '0;
        for (int i = 1; i < WAYS; i++) begin
          if ((WW+1)'(i) < nways && rdata[i][AGE_BITS-1:0] > best) begin
            best = rdata[i][AGE_BITS-1:0];
            sel_way = WW'(i);
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      wdata[i] = rdata[i];
      if (state == ST_CLR) begin
        wdata[i] = '0;
      end else if ((WW+1)'(i) < nways) begin
        if (WW'(i) == sel_way) begin
          wdata[i][AGE_BITS-1:0] = '0;
          if (!hit) begin
            wdata[i][AGE_BITS] = 1'b1;
            wdata[i][EW-1:AGE_BITS+1] = cur.tag;
          end
        end else if (rdata[i][AGE_BITS-1:0] != AGE_MAX) begin
          wdata[i][AGE_BITS-1:0] = rdata[i][AGE_BITS-1:0] + 1'b1;
        end
      end
    end
  end

  assign raddr   = q_req.set[SW-1:0];
  assign waddr   = (state == ST_CLR) ? clr_set : cur.set[SW-1:0];
  assign we      = (state == ST_CLR) || (state == ST_READ);
  assign q_ready = (state == ST_IDLE) && !out_valid;
  assign busy    = (state != ST_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_set   <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        ref_cnt[k]  <= '0;
        miss_cnt[k] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_set <= clr_set + 1'b1;
          if (32'(clr_set) == SETS - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            cur   <= q_req;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          out_hit   <= hit;
          out_way   <= 2'(sel_way);
          out_ref_count  <= '0;
          out_miss_count <= '0;
          if (cur.action != ACT_OTHER) begin
            if (ref_cnt[cur.action] != '1) begin
              ref_cnt[cur.action] <= ref_cnt[cur.action] + 1'b1;
              out_ref_count <= ref_cnt[cur.action] + 1'b1;
            end else begin
              out_ref_count <= ref_cnt[cur.action];
            end
            if (!hit && miss_cnt[cur.action] != '1) begin
              miss_cnt[cur.action] <= miss_cnt[cur.action] + 1'b1;
              out_miss_count <= miss_cnt[cur.action] + 1'b1;
            end else begin
              out_miss_count <= miss_cnt[cur.action];
            end
          end
          state <= ST_WB;
        end
        ST_WB: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_lookup_core.sv =====
// an accepted request passes through the two deep queue, the back end's
//   request register (while its set is read and written back) and the result
//   register; the back end takes the next request only when idle with no result waiting
// after reset a clearing pass over all SETS sets zeroes tags, valid bits and
//   ages; requests queue (two deep) but are not processed during it
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core
// set associative cache lookup with age based lru replacement
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module set_assoc_cache_lru_lookup_core
  import salru_pkg::*;
#(
  parameter int SETS     = 256,
  parameter int WAYS     = 4,
  parameter int AGE_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // address
  input  wire logic [1:0]  s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // way, kind_reference_count, kind_miss_count, pad
  output logic             m_axis_tuser,   // hit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  logic [3:0] offset_bits;
  logic [3:0] index_bits;
  logic [2:0] active_ways;
  logic       q_valid;
  logic       q_ready;
  salru_req_t q_req;
  logic       hit;
  logic [1:0] way;
  logic [31:0] rc;
  logic [31:0] mc;
  logic       busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd6;
      index_bits  <= 4'd8;
      active_ways <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_INDEX_BITS:  index_bits  <= cfg_data;
        REG_ACTIVE_WAYS: active_ways <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  salru_front #(.SETS(SETS)) u_front (
    .clk(clk), .rst(rst),
    .offset_bits(offset_bits), .index_bits(index_bits),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_action(s_axis_tuser), .in_address(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  salru_back #(.SETS(SETS), .WAYS(WAYS), .AGE_BITS(AGE_BITS)) u_back (
    .clk(clk), .rst(rst), .active_ways(active_ways),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_hit(hit), .out_way(way), .out_ref_count(rc), .out_miss_count(mc),
    .busy(busy)
  );

  assign m_axis_tuser = hit;
  assign m_axis_tdata = {6'd0, mc, rc, way};

  `ASSERT_CLK(a_miss_le_ref, clk, rst, !m_axis_tvalid || mc <= rc)
  `ASSERT_CLK(a_hold_out, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_CLK(a_busy_out, clk, rst, !m_axis_tvalid || busy)

endmodule

`default_nettype wire

// ===== tb/sv/salru_checker.sv =====
// ----------------------------------------------------------------------------
// salru_checker
// watches the request, result and register channels of the cache lookup,
// keeps its own copy of tags, valid bits, ages and counters, and compares
// every result with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module salru_checker
  import salru_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  output int               errors,
  output int               pending
);

  localparam int NSETS = 256;
  localparam int NWAYS = 4;
  localparam logic [7:0] AGE_TOP = 8'hff;
  localparam logic [31:0] COUNT_TOP = 32'hffff_ffff;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] refs;
    logic [31:0] misses;
  } lookup_t;

  logic [3:0]  offset_bits;
  logic [3:0]  index_bits;
  logic [2:0]  active_ways;
  logic        valid_q [NSETS*NWAYS];
  logic [63:0] tag_q   [NSETS*NWAYS];
  logic [7:0]  age_q   [NSETS*NWAYS];
  logic [31:0] refs_q  [3];
  logic [31:0] miss_q  [3];
  lookup_t     expected_lookups [$];

  assign pending = expected_lookups.size();

  task automatic predict_lookup(input logic [1:0] act, input logic [63:0] addr);
    int nw, base, w, i;
    logic [63:0] imask, tag;
    logic found;
    lookup_t r;
    nw = (active_ways == 0) ? 1 : (active_ways > NWAYS) ? NWAYS : active_ways;
    imask = (64'd1 << index_bits) - 64'd1;
    base = int'(((addr >> offset_bits) & imask) % NSETS) * NWAYS;
    tag = addr >> (int'(offset_bits) + int'(index_bits));
    found = 1'b0;
    w = 0;
    for (i = 0; i < nw; i++) begin
      if (!found && valid_q[base+i] && tag_q[base+i] == tag) begin
        found = 1'b1;
        w = i;
      end
    end
    if (!found) begin
      w = -1;
      for (i = 0; i < nw; i++)
        if (w < 0 && !valid_q[base+i]) w = i;
      // no free way: oldest wins, lowest way on ties
      if (w < 0) begin
        w = 0;
        for (i = 1; i < nw; i++)
          if (age_q[base+i] > age_q[base+w]) w = i;
      end
      tag_q[base+w] = tag;
      valid_q[base+w] = 1'b1;
    end
    for (i = 0; i < nw; i++) begin
      if (i == w) age_q[base+i] = '0;
      else if (age_q[base+i] != AGE_TOP) age_q[base+i]++;
    end
    r.hit = found;
    r.way = w[1:0];
    r.refs = '0;
    r.misses = '0;
    if (act != ACT_OTHER) begin
      if (refs_q[act] != COUNT_TOP) refs_q[act]++;
      if (!found && miss_q[act] != COUNT_TOP) miss_q[act]++;
      r.refs = refs_q[act];
      r.misses = miss_q[act];
    end
    expected_lookups.push_back(r);
  endtask

  always @(posedge clk) begin
    lookup_t e, a;
    if (rst) begin
      offset_bits <= 4'd6;
      index_bits <= 4'd8;
      active_ways <= 3'd4;
      for (int i = 0; i < NSETS*NWAYS; i++) begin
        valid_q[i] = 1'b0;
        tag_q[i] = '0;
        age_q[i] = '0;
      end
      for (int k = 0; k < 3; k++) begin
        refs_q[k] = '0;
        miss_q[k] = '0;
      end
      expected_lookups.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_BITS: offset_bits <= cfg_data;
          REG_INDEX_BITS:  index_bits <= cfg_data;
          REG_ACTIVE_WAYS: active_ways <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_lookup(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        a.hit = m_axis_tuser;
        a.way = m_axis_tdata[1:0];
        a.refs = m_axis_tdata[33:2];
        a.misses = m_axis_tdata[65:34];
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result hit=%0b way=%0d refs=%0d misses=%0d",
                   $time, a.hit, a.way, a.refs, a.misses);
          errors <= errors + 1;
        end else begin
          e = expected_lookups.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected hit=%0b way=%0d refs=%0d misses=%0d",
                     $time, e.hit, e.way, e.refs, e.misses);
            $display("%0t:          actual   hit=%0b way=%0d refs=%0d misses=%0d",
                     $time, a.hit, a.way, a.refs, a.misses);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives references and register writes into the cache lookup with random
// gaps and back pressure; the checker predicts and compares the results
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import salru_pkg::*;
;

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 300;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // address
  logic [1:0]  s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // way, kind_reference_count, kind_miss_count, pad
  logic        m_axis_tuser;   // hit
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;
  int          errors;
  int          pending;

  logic        send_calm;
  logic        recv_calm;
  logic        hold_long;
  int          cur_offset;
  int          cur_index;

  set_assoc_cache_lru_lookup_core u_dut (.*);

  salru_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side back pressure
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = recv_calm ? 0 : $urandom_range(0, 16);
      if (hold_long) begin
        hold_long = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_request(input logic [1:0] act, input logic [63:0] addr);
    int n;
    n = send_calm ? 0 : $urandom_range(0, 16);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= addr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_geometry(input int ob, input int ib, input int nw);
    drain();
    write_reg(REG_OFFSET_BITS, ob[3:0]);
    write_reg(REG_INDEX_BITS, ib[3:0]);
    write_reg(REG_ACTIVE_WAYS, nw[3:0]);
    cfg_valid <= 1'b0;
    cur_offset = ob;
    cur_index = ib;
  endtask

  // mostly a few tags over a few sets so that hits and evictions happen
  function automatic logic [63:0] pick_address();
    logic [63:0] t, s, o;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    t = $urandom_range(0, 6);
    s = $urandom_range(0, 3);
    o = {$urandom, $urandom};
    return (t << (cur_offset + cur_index)) |
           ((s & ((64'd1 << cur_index) - 1)) << cur_offset) |
           (o & ((64'd1 << cur_offset) - 1));
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      send_request(2'($urandom_range(0, 3)), pick_address());
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_INSTR;
    cfg_valid = 1'b0;
    cfg_index = REG_OFFSET_BITS;
    cfg_data = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_long = 1'b0;
    cur_offset = 6;
    cur_index = 8;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset geometry, one set filled past its ways, hits, extremes
    send_request(ACT_INSTR, 64'd0);
    send_request(ACT_READ, 64'd0);
    send_request(ACT_WRITE, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_OTHER, 64'hffff_ffff_ffff_ffff);
    for (int t = 1; t <= 5; t++) send_request(ACT_READ, 64'(t) << 14);
    send_request(ACT_WRITE, 64'd3 << 14);
    send_request(ACT_INSTR, 64'd2 << 14);
    send_request(ACT_OTHER, 64'd6 << 14);
    send_request(ACT_READ, 64'h8000_0000_0000_0000);
    send_request(ACT_READ, 64'h0000_0000_0000_3fff);
    send_request(ACT_WRITE, 64'h5555_5555_5555_5555);
    send_request(ACT_WRITE, 64'haaaa_aaaa_aaaa_aaaa);

    set_geometry(0, 0, 1);
    send_request(ACT_INSTR, 64'd7);
    send_request(ACT_INSTR, 64'd7);
    send_request(ACT_READ, 64'd8);
    // active ways of zero acts as one, above four acts as four
    set_geometry(6, 8, 0);
    send_request(ACT_READ, 64'd1 << 14);
    send_request(ACT_READ, 64'd2 << 14);
    send_request(ACT_WRITE, 64'd1 << 14);
    set_geometry(6, 8, 7);
    send_request(ACT_OTHER, 64'd9 << 14);

    set_geometry(6, 8, 4);
    random_phase(300);
    // receiver stops for a long while so the request queue fills
    send_calm = 1'b1;
    hold_long = 1'b1;
    for (int i = 0; i < 40; i++) send_request(2'($urandom_range(0, 3)), pick_address());
    set_geometry(12, 8, 4);
    random_phase(250);
    set_geometry(0, 0, 1);
    random_phase(150);
    set_geometry(15, 15, 7);
    random_phase(250);
    set_geometry(3, 2, 2);
    random_phase(250);
    set_geometry(4, 1, 3);
    random_phase(250);
    set_geometry(5, 10, 4);
    random_phase(300);
    drain();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/salru_pkg.sv
rtl/salru_ram.sv
rtl/salru_front.sv
rtl/salru_back.sv
rtl/set_assoc_cache_lru_lookup_core.sv
tb/sv/salru_checker.sv
tb/sv/tb.sv
